// ===== sv/bmt_pkg.sv =====
`default_nettype none
package bmt_pkg;

  // Table size default
  localparam int unsigned TableDepthDefault = 16;

  localparam int unsigned AddrW  = 32;
  localparam int unsigned IdW    = 16;
  localparam int unsigned CountW = 32;

  // Operation codes
  typedef enum logic [1:0] {
    FUNC_ADD    = 2'd0,
    FUNC_DELETE = 2'd1,
    FUNC_SEARCH = 2'd2,
    FUNC_NONE   = 2'd3
  } func_t;

  // Result status codes
  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_MISS  = 2'd1,
    ST_FULL  = 2'd2,
    ST_UNUSED = 2'd3
  } status_t;

  localparam logic [IdW-1:0] IdFirst = IdW'(1);
  localparam logic [IdW-1:0] IdLast  = {IdW{1'b1}};
  localparam logic [CountW-1:0] CountMax = {CountW{1'b1}};

  // Request token that walks the row of cells
  typedef struct packed {
    logic              valid;
    func_t             func;
    logic [AddrW-1:0]  addr;
    logic [IdW-1:0]    bp_id;
    logic [IdW-1:0]    new_id;
    logic              done;
    status_t           status;
    logic [IdW-1:0]    assigned_id;
    logic [CountW-1:0] visit_count;
  } token_t;

endpackage
`default_nettype wire

// ===== sv/bmt_cell.sv =====
`default_nettype none
module bmt_cell (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            adv,
  input  wire bmt_pkg::token_t tok_in,
  output bmt_pkg::token_t      tok_out
);

  // Entry held by this cell
  logic                        live;
  logic [bmt_pkg::IdW-1:0]     ident;
  logic [bmt_pkg::AddrW-1:0]   address;
  logic [bmt_pkg::CountW-1:0]  visits;

  logic                        act;
  logic                        hit_add;
  logic                        hit_del;
  logic                        hit_srch;
  logic [bmt_pkg::CountW-1:0]  visits_next;
  bmt_pkg::token_t             tok_next;

  assign act = adv && tok_in.valid && !tok_in.done;

  // Match terms for each operation
  assign hit_add  = (tok_in.func == bmt_pkg::FUNC_ADD) && !live;
  assign hit_del  = (tok_in.func == bmt_pkg::FUNC_DELETE) && live &&
                    (ident == tok_in.bp_id);
  assign hit_srch = (tok_in.func == bmt_pkg::FUNC_SEARCH) && live &&
                    (address == tok_in.addr);

  // Saturating visit count
  assign visits_next = (visits == bmt_pkg::CountMax) ? visits
                                                     : visits + bmt_pkg::CountW'(1);

  // Token as it leaves this cell
  always_comb begin
    tok_next = tok_in;
    if (!tok_in.done) begin
      if (hit_add) begin
        tok_next.done        = 1'b1;
        tok_next.status      = bmt_pkg::ST_DONE;
        tok_next.assigned_id = tok_in.new_id;
      end else if (hit_del) begin
        tok_next.done   = 1'b1;
        tok_next.status = bmt_pkg::ST_DONE;
      end else if (hit_srch) begin
        tok_next.done        = 1'b1;
        tok_next.status      = bmt_pkg::ST_DONE;
        tok_next.visit_count = visits_next;
      end
    end
  end

  // Live mark and token valid
  always_ff @(posedge clk) begin
    if (rst) begin
      live          <= 1'b0;
      tok_out.valid <= 1'b0;
    end else begin
      if (adv) begin
        tok_out.valid <= tok_in.valid;
      end
      if (act && hit_add) begin
        live <= 1'b1;
      end else if (act && hit_del) begin
        live <= 1'b0;
      end
    end
  end

  // Entry payload and token payload
  always_ff @(posedge clk) begin
    if (act && hit_add) begin
      ident   <= tok_in.new_id;
      address <= tok_in.addr;
      visits  <= '0;
    end else if (act && hit_srch) begin
      visits <= visits_next;
    end
    if (adv) begin
      tok_out.func        <= tok_next.func;
      tok_out.addr        <= tok_next.addr;
      tok_out.bp_id       <= tok_next.bp_id;
      tok_out.new_id      <= tok_next.new_id;
      tok_out.done        <= tok_next.done;
      tok_out.status      <= tok_next.status;
      tok_out.assigned_id <= tok_next.assigned_id;
      tok_out.visit_count <= tok_next.visit_count;
    end
  end

endmodule
`default_nettype wire

// ===== sv/breakpoint_match_table.sv =====
// Breakpoint table of TABLE_DEPTH entries built as a row of cells, one entry
// per cell. An accepted request (add, delete by id, search by address) enters
// a token register and then walks the row one cell per cycle; the first cell
// that matches acts on its entry and marks the token done, later cells pass it
// on. The token passes from the token register through every cell, and the
// result register at the output is loaded from the token that leaves the
// last cell. One request is in the row at a time, so a new request is taken
// the cycle after the previous token leaves the row, and not before. A waiting
// result does not hold off the next request; only a stalled result with a
// second token arriving behind it freezes the row.
`default_nettype none
module breakpoint_match_table #(
  parameter int unsigned TABLE_DEPTH = bmt_pkg::TableDepthDefault
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        req_valid,
  output logic                             req_stall,
  input  wire logic [1:0]                  func,
  input  wire logic [bmt_pkg::AddrW-1:0]   addr,
  input  wire logic [bmt_pkg::IdW-1:0]     bp_id,
  output logic                             rsp_valid,
  input  wire logic                        rsp_stall,
  output logic [1:0]                       status,
  output logic [bmt_pkg::IdW-1:0]          assigned_id,
  output logic [bmt_pkg::CountW-1:0]       visit_count
);

  bmt_pkg::token_t           tok [TABLE_DEPTH+1];
  logic [TABLE_DEPTH:0]      tok_vld;
  logic                      busy;
  logic                      adv;
  logic                      fin;
  logic                      accept;
  logic [bmt_pkg::IdW-1:0]   next_ident;
  bmt_pkg::token_t           last;

  assign last      = tok[TABLE_DEPTH];
  assign req_stall = busy;
  assign accept    = req_valid && !busy;
  assign adv       = !(last.valid && rsp_valid && rsp_stall);
  assign fin       = last.valid && adv;

  // Entry token register
  always_ff @(posedge clk) begin
    if (rst) begin
      tok[0].valid <= 1'b0;
    end else if (accept) begin
      tok[0].valid <= 1'b1;
    end else if (adv) begin
      tok[0].valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      tok[0].func        <= bmt_pkg::func_t'(func);
      tok[0].addr        <= addr;
      tok[0].bp_id       <= bp_id;
      tok[0].new_id      <= next_ident;
      tok[0].done        <= 1'b0;
      tok[0].status      <= (bmt_pkg::func_t'(func) == bmt_pkg::FUNC_ADD) ?
                            bmt_pkg::ST_FULL : bmt_pkg::ST_MISS;
      tok[0].assigned_id <= '0;
      tok[0].visit_count <= '0;
    end
  end

  // Row of cells
  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    bmt_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .adv     (adv),
      .tok_in  (tok[i]),
      .tok_out (tok[i+1])
    );
  end

  for (genvar i = 0; i <= TABLE_DEPTH; i++) begin : g_vld
    assign tok_vld[i] = tok[i].valid;
  end

  // Control: busy flag, id counter, result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      busy       <= 1'b0;
      next_ident <= bmt_pkg::IdFirst;
      rsp_valid  <= 1'b0;
    end else begin
      if (accept) begin
        busy <= 1'b1;
      end else if (fin) begin
        busy <= 1'b0;
      end
      if (fin && last.func == bmt_pkg::FUNC_ADD && last.done) begin
        next_ident <= (last.new_id == bmt_pkg::IdLast) ? bmt_pkg::IdFirst
                                                       : last.new_id + bmt_pkg::IdW'(1);
      end
      if (fin) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (fin) begin
      status      <= last.status;
      assigned_id <= last.assigned_id;
      visit_count <= last.visit_count;
    end
  end

  // At most one token in the row
  a_one_token: assert property (@(posedge clk) disable iff (rst)
    $onehot0(tok_vld))
    else $error("more than one token in cell row");

  // No token walks the row while idle
  a_idle_empty: assert property (@(posedge clk) disable iff (rst)
    !busy |-> (tok_vld == '0))
    else $error("token present while idle");

  // A new result only comes from a token leaving the row
  a_rsp_src: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(last.valid))
    else $error("result without token");

  // Only a successful add reports an id
  a_id_ok: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && status != bmt_pkg::ST_DONE |-> assigned_id == '0)
    else $error("id reported on failed request");

endmodule
`default_nettype wire

// ===== sim/tb.sv =====
`timescale 1ns / 1ps

module tb;

  localparam int unsigned Depth = bmt_pkg::TableDepthDefault;

  // Expected response of one request
  typedef struct {
    bmt_pkg::status_t           status;
    logic [bmt_pkg::IdW-1:0]    assigned_id;
    logic [bmt_pkg::CountW-1:0] visit_count;
  } bp_result_t;

  // Shadow copy of the breakpoint table plus the queue of responses it predicts
  class breakpoint_shadow;
    bit                         live [Depth];
    logic [bmt_pkg::IdW-1:0]    ident [Depth];
    logic [bmt_pkg::AddrW-1:0]  bp_addr [Depth];
    logic [bmt_pkg::CountW-1:0] visits [Depth];
    logic [bmt_pkg::IdW-1:0]    next_id;
    bp_result_t                 pending [$];
    int                         accepted;
    int                         failures;

    function new();
      foreach (live[k]) live[k] = 1'b0;
      next_id  = bmt_pkg::IdFirst;
      accepted = 0;
      failures = 0;
    endfunction

    function int live_count();
      int cnt;
      cnt = 0;
      foreach (live[k]) if (live[k]) cnt++;
      return cnt;
    endfunction

    // Random live slot, -1 when the table is empty
    function int random_live_slot();
      int picks [$];
      foreach (live[k]) if (live[k]) picks.push_back(k);
      if (picks.size() == 0) return -1;
      return picks[$urandom_range(0, picks.size() - 1)];
    endfunction

    // Apply one accepted request to the shadow table and queue its response
    function void note_request(logic [1:0] op, logic [bmt_pkg::AddrW-1:0] a,
                               logic [bmt_pkg::IdW-1:0] id);
      bp_result_t want;
      int         k;
      want.status      = bmt_pkg::ST_MISS;
      want.assigned_id = '0;
      want.visit_count = '0;
      accepted++;
      case (bmt_pkg::func_t'(op))
        bmt_pkg::FUNC_ADD: begin
          want.status = bmt_pkg::ST_FULL;
          for (k = 0; k < Depth; k++) begin
            if (!live[k]) begin
              live[k]          = 1'b1;
              ident[k]         = next_id;
              bp_addr[k]       = a;
              visits[k]        = '0;
              want.status      = bmt_pkg::ST_DONE;
              want.assigned_id = next_id;
              next_id = (next_id == bmt_pkg::IdLast) ? bmt_pkg::IdFirst
                                                     : next_id + bmt_pkg::IdW'(1);
              break;
            end
          end
        end
        bmt_pkg::FUNC_DELETE: begin
          for (k = 0; k < Depth; k++) begin
            if (live[k] && ident[k] == id) begin
              live[k]     = 1'b0;
              want.status = bmt_pkg::ST_DONE;
              break;
            end
          end
        end
        bmt_pkg::FUNC_SEARCH: begin
          for (k = 0; k < Depth; k++) begin
            if (live[k] && bp_addr[k] == a) begin
              if (visits[k] != bmt_pkg::CountMax)
                visits[k] = visits[k] + bmt_pkg::CountW'(1);
              want.status      = bmt_pkg::ST_DONE;
              want.visit_count = visits[k];
              break;
            end
          end
        end
        default: ;  // unused selector: miss, table untouched
      endcase
      pending.push_back(want);
    endfunction

    function void report_field(string name, logic [bmt_pkg::CountW-1:0] want,
                               logic [bmt_pkg::CountW-1:0] got);
      failures++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    endfunction

    // Compare one accepted response against the oldest prediction
    function void check_result(logic [1:0] got_status, logic [bmt_pkg::IdW-1:0] got_id,
                               logic [bmt_pkg::CountW-1:0] got_count);
      bp_result_t want;
      if (pending.size() == 0) begin
        failures++;
        $display("%0t: response with none outstanding, actual status %0d id %0d count %0d",
                 $time, got_status, got_id, got_count);
        return;
      end
      want = pending.pop_front();
      if (got_status !== want.status)
        report_field("status", bmt_pkg::CountW'(want.status), bmt_pkg::CountW'(got_status));
      if (got_id !== want.assigned_id)
        report_field("assigned_id", bmt_pkg::CountW'(want.assigned_id),
                     bmt_pkg::CountW'(got_id));
      if (got_count !== want.visit_count)
        report_field("visit_count", want.visit_count, got_count);
    endfunction
  endclass

  logic                       clk;
  logic                       rst;
  logic                       req_valid;
  logic                       req_stall;
  logic [1:0]                 func;
  logic [bmt_pkg::AddrW-1:0]  addr;
  logic [bmt_pkg::IdW-1:0]    bp_id;
  logic                       rsp_valid;
  logic                       rsp_stall;
  logic [1:0]                 status;
  logic [bmt_pkg::IdW-1:0]    assigned_id;
  logic [bmt_pkg::CountW-1:0] visit_count;

  breakpoint_shadow          book;
  bit                        steady;
  logic [bmt_pkg::AddrW-1:0] addr_pool [8];

  breakpoint_match_table #(.TABLE_DEPTH(Depth)) DUT (
    .clk         (clk),
    .rst         (rst),
    .req_valid   (req_valid),
    .req_stall   (req_stall),
    .func        (func),
    .addr        (addr),
    .bp_id       (bp_id),
    .rsp_valid   (rsp_valid),
    .rsp_stall   (rsp_stall),
    .status      (status),
    .assigned_id (assigned_id),
    .visit_count (visit_count)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Idle length: mostly none or short, now and then long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 20);
    return $urandom_range(30, 80);
  endfunction

  // Offer one request from a falling edge; return on the falling edge after it is taken
  task automatic send_request(input bmt_pkg::func_t op, input logic [bmt_pkg::AddrW-1:0] a,
                              input logic [bmt_pkg::IdW-1:0] id);
    int gap;
    gap = steady ? 0 : pick_gap();
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_valid <= 1'b1;
    func      <= op;
    addr      <= a;
    bp_id     <= id;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    @(negedge clk);
  endtask

  // Both handshakes observed at the rising edge
  always @(posedge clk) begin
    if (!rst) begin
      if (rsp_valid && !rsp_stall) book.check_result(status, assigned_id, visit_count);
      if (req_valid && !req_stall) book.note_request(func, addr, bp_id);
    end
  end

  // Response side: random stalls, one long hold-off to back up the table
  initial begin : rsp_side
    int run;
    int hold;
    bit held;
    held      = 1'b0;
    rsp_stall = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (!held && book.accepted >= 400) begin
        held = 1'b1;
        rsp_stall <= 1'b1;
        repeat (300) @(negedge clk);
      end
      run  = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 6);
      hold = pick_gap();
      rsp_stall <= 1'b0;
      repeat (run) @(negedge clk);
      if (hold > 0) begin
        rsp_stall <= 1'b1;
        repeat (hold) @(negedge clk);
      end
    end
  end

  initial begin : stimulus
    int                        n;
    int                        k;
    int                        occ;
    int                        roll;
    int                        pick;
    int                        slot;
    int                        add_cut;
    int                        del_cut;
    bmt_pkg::func_t            op;
    logic [bmt_pkg::AddrW-1:0] a;
    logic [bmt_pkg::IdW-1:0]   id;

    book      = new();
    steady    = 1'b0;
    rst       = 1'b1;
    req_valid = 1'b0;
    func      = bmt_pkg::FUNC_ADD;
    addr      = '0;
    bp_id     = '0;
    foreach (addr_pool[k]) addr_pool[k] = $urandom;
    addr_pool[0] = 32'hFFFF_FFFF;

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: empty table, bad ids, unused selector, fill to full, duplicates
    send_request(bmt_pkg::FUNC_SEARCH, 32'h0, 16'h0);
    send_request(bmt_pkg::FUNC_DELETE, 32'h0, 16'h0);
    send_request(bmt_pkg::FUNC_NONE, 32'hFFFF_FFFF, 16'hFFFF);
    send_request(bmt_pkg::FUNC_ADD, 32'h0, 16'hFFFF);
    send_request(bmt_pkg::FUNC_ADD, 32'hFFFF_FFFF, 16'h0);
    send_request(bmt_pkg::FUNC_ADD, 32'h0, 16'h0);           // duplicate address
    for (k = 3; k < Depth; k++)
      send_request(bmt_pkg::FUNC_ADD, addr_pool[k % 8], 16'($urandom));
    send_request(bmt_pkg::FUNC_ADD, 32'h1234_5678, 16'h0);   // table full
    send_request(bmt_pkg::FUNC_SEARCH, 32'h0, 16'h0);        // lowest duplicate hits
    send_request(bmt_pkg::FUNC_DELETE, 32'h0, 16'd1);
    send_request(bmt_pkg::FUNC_SEARCH, 32'h0, 16'h0);        // next duplicate hits now
    send_request(bmt_pkg::FUNC_DELETE, 32'h0, 16'd1);        // already freed
    send_request(bmt_pkg::FUNC_ADD, 32'hA5A5_5A5A, 16'h0);   // reuses the freed slot

    // Random mix; add/delete weights keep occupancy moving between empty and full
    for (n = 0; n < 1150; n++) begin
      if (n % 64 == 0) steady = ($urandom_range(0, 3) == 0);
      occ     = book.live_count();
      roll    = $urandom_range(0, 99);
      add_cut = (occ < 12) ? 40 : 25;
      del_cut = add_cut + ((occ > 8) ? 35 : 15);
      slot    = book.random_live_slot();
      op      = bmt_pkg::FUNC_SEARCH;
      a       = $urandom;
      id      = 16'($urandom);
      if (roll < 3) begin
        op = bmt_pkg::FUNC_NONE;
      end else if (roll < 3 + add_cut) begin
        op = bmt_pkg::FUNC_ADD;
        if ($urandom_range(0, 3) != 0) a = addr_pool[$urandom_range(0, 7)];
      end else if (roll < 3 + del_cut) begin
        op = bmt_pkg::FUNC_DELETE;
        if (slot >= 0 && $urandom_range(0, 4) != 0) id = book.ident[slot];
      end else begin
        pick = $urandom_range(0, 9);
        if (pick < 6) a = addr_pool[$urandom_range(0, 7)];
        else if (pick < 8 && slot >= 0) a = book.bp_addr[slot];
      end
      send_request(op, a, id);
    end
    req_valid <= 1'b0;

    while (book.pending.size() != 0) @(negedge clk);
    repeat (2 * Depth + 8) @(negedge clk);
    if (book.failures == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Run limit
  initial begin : watchdog
    #20_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule

// ===== files.f =====
sv/bmt_pkg.sv
sv/bmt_cell.sv
sv/breakpoint_match_table.sv
sim/tb.sv
